FILE: src/upsc_pkg.sv
package upsc_pkg;

	// line buffer geometry
	localparam int MAX_WIDTH = 4096;
	localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CNT_W     = ADDR_W + 1;

	// register and field widths
	localparam int SCALE_W     = 7;
	localparam int ROW_WIDTH_W = 13;
	localparam int COLOR_W     = 8;
	localparam int PIX_W       = 3 * COLOR_W;
	localparam int PAD_W       = 2;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [SCALE_W-1:0] SCALE_LIMIT = SCALE_W'(100);

	// register index codes, taken from paddr[2]
	localparam logic REG_SCALE     = 1'b0;
	localparam logic REG_ROW_WIDTH = 1'b1;

	// item function codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [CNT_W-1:0]   width;
		logic [PAD_W-1:0]   pad;
	} cfg_t;

	typedef struct packed {
		logic [PAD_W-1:0] pad_bytes;
		logic             row_end;
		logic             group_end;
		logic             dropped;
	} meta_t;

	typedef struct packed {
		logic  valid;
		meta_t meta;
	} res_t;

endpackage

FILE: src/upsc_if.sv
interface upsc_in_if import upsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               func;
	logic [COLOR_W-1:0] in_blue;
	logic [COLOR_W-1:0] in_green;
	logic [COLOR_W-1:0] in_red;

	modport source (output valid, func, in_blue, in_green, in_red, input ready);
	modport sink (input valid, func, in_blue, in_green, in_red, output ready);
endinterface

interface upsc_out_if import upsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] out_blue;
	logic [COLOR_W-1:0] out_green;
	logic [COLOR_W-1:0] out_red;
	logic [PAD_W-1:0]   pad_bytes;
	logic               row_end;
	logic               group_end;
	logic               dropped;

	modport source (
		output valid, out_blue, out_green, out_red, pad_bytes, row_end, group_end, dropped,
		input ready
	);
	modport sink (
		input valid, out_blue, out_green, out_red, pad_bytes, row_end, group_end, dropped,
		output ready
	);
endinterface

FILE: src/upsc_ram.sv
module upsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/upsc_cfg.sv
module upsc_cfg import upsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	logic [SCALE_W-1:0]     scale_q;
	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic                   wr_en;
	logic [SCALE_W-1:0]     eff_n;
	logic [CNT_W-1:0]       eff_w;
	logic [PAD_W-1:0]       bytes_lo;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_W'(1);
			row_width_q <= ROW_WIDTH_W'(1);
		end else if (wr_en) begin
			case (paddr[2])
				REG_SCALE:     scale_q     <= pwdata[SCALE_W-1:0];
				REG_ROW_WIDTH: row_width_q <= pwdata[ROW_WIDTH_W-1:0];
				default:       scale_q     <= scale_q;
			endcase
		end
	end

	// misaligned reads return zero
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'd0) begin
			case (paddr[2])
				REG_SCALE:     prdata = PDATA_W'(scale_q);
				REG_ROW_WIDTH: prdata = PDATA_W'(row_width_q);
				default:       prdata = '0;
			endcase
		end
	end

	// effective values with clamping
	always_comb begin
		if (scale_q == '0) begin
			eff_n = SCALE_W'(1);
		end else if (scale_q > SCALE_LIMIT) begin
			eff_n = SCALE_LIMIT;
		end else begin
			eff_n = scale_q;
		end
		if (row_width_q == '0) begin
			eff_w = CNT_W'(1);
		end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = CNT_W'(MAX_WIDTH);
		end else begin
			eff_w = CNT_W'(row_width_q);
		end
	end

	// low two bits of 3*w*n, then pad to a multiple of four
	assign bytes_lo  = PAD_W'(PAD_W'(eff_w[1:0] * eff_n[1:0]) * 2'd3);
	assign cfg.scale = eff_n;
	assign cfg.width = eff_w;
	assign cfg.pad   = PAD_W'(2'd0 - bytes_lo);

endmodule

FILE: src/upsc_seq.sv
module upsc_seq import upsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              accept,
	input  logic              func,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	output res_t              res
);

	logic               emitting_q, emitting_d;
	logic [ADDR_W-1:0]  load_col_q, load_col_d;
	logic [ADDR_W-1:0]  emit_col_q, emit_col_d;
	logic [SCALE_W-1:0] hcopy_q, hcopy_d;
	logic [SCALE_W-1:0] vcopy_q, vcopy_d;
	logic [CNT_W-1:0]   load_nx, emit_nx;
	logic [SCALE_W:0]   hcopy_nx, vcopy_nx;

	assign load_nx   = CNT_W'(load_col_q) + CNT_W'(1);
	assign emit_nx   = CNT_W'(emit_col_q) + CNT_W'(1);
	assign hcopy_nx  = (SCALE_W+1)'(hcopy_q) + (SCALE_W+1)'(1);
	assign vcopy_nx  = (SCALE_W+1)'(vcopy_q) + (SCALE_W+1)'(1);
	assign ram_waddr = load_col_q;
	assign ram_raddr = emit_col_q;

	always_comb begin
		emitting_d = emitting_q;
		load_col_d = load_col_q;
		emit_col_d = emit_col_q;
		hcopy_d    = hcopy_q;
		vcopy_d    = vcopy_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		res        = '0;
		if (accept) begin
			if (func == FUNC_PUSH) begin
				if (emitting_q) begin
					res.valid        = 1'b1;
					res.meta.dropped = 1'b1;
				end else begin
					ram_we = 1'b1;
					if (load_nx >= cfg.width) begin
						load_col_d = '0;
						emitting_d = 1'b1;
						emit_col_d = '0;
						hcopy_d    = '0;
						vcopy_d    = '0;
					end else begin
						load_col_d = load_nx[ADDR_W-1:0];
					end
				end
			end else if (emitting_q) begin
				ram_re    = 1'b1;
				res.valid = 1'b1;
				if (hcopy_nx >= (SCALE_W+1)'(cfg.scale)) begin
					hcopy_d = '0;
					if (emit_nx >= cfg.width) begin
						emit_col_d         = '0;
						res.meta.row_end   = 1'b1;
						res.meta.pad_bytes = cfg.pad;
						if (vcopy_nx >= (SCALE_W+1)'(cfg.scale)) begin
							vcopy_d            = '0;
							res.meta.group_end = 1'b1;
							emitting_d         = 1'b0;
							load_col_d         = '0;
						end else begin
							vcopy_d = vcopy_nx[SCALE_W-1:0];
						end
					end else begin
						emit_col_d = emit_nx[ADDR_W-1:0];
					end
				end else begin
					hcopy_d = hcopy_nx[SCALE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitting_q <= 1'b0;
			load_col_q <= '0;
			emit_col_q <= '0;
			hcopy_q    <= '0;
			vcopy_q    <= '0;
		end else begin
			emitting_q <= emitting_d;
			load_col_q <= load_col_d;
			emit_col_q <= emit_col_d;
			hcopy_q    <= hcopy_d;
			vcopy_q    <= vcopy_d;
		end
	end

endmodule

FILE: src/pixel_replicate_upscaler_unit.sv
// Integer nearest-neighbor upscaler for 24-bit pixels. Push transactions (func 0) load one
// source row of row_width pixels into a line buffer; after the last one the block switches
// to emitting, and each pull transaction (func 1) returns one output pixel: every pixel is
// repeated scale times and the row is sent scale times. The last pixel of each output row
// carries row_end and the row padding byte count, the last pixel of the final copy also
// carries group_end, and the block then goes back to loading. A push while emitting is
// discarded and answered with a dropped result; a pull while loading gives no result.
// Throughput is one transaction per cycle while rsp is not stalled, since every transaction
// makes at most one access to the line buffer (a write for a push, a read for a pull). A
// result passes through stage 1, which waits for the buffer read, and then the output register
// before it shows on rsp. Configuration goes through the APB port (scale at 0x0, row_width at
// 0x4); the user must write it only while the block is idle, which the block does not enforce.
module pixel_replicate_upscaler_unit import upsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	upsc_in_if.sink            req,
	upsc_out_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t              cfg;
	res_t              res;
	logic              accept;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	pixel_t            ram_wdata, ram_rdata;

	// stage 1: waits for the buffer read data
	logic              s1_valid_s1;
	meta_t             s1_meta_s1;

	// output register
	logic              out_valid_q;
	meta_t             out_meta_q;
	pixel_t            out_pix_q;
	logic              out_adv;

	assign pready = 1'b1;

	upsc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// output register frees up when empty or its transaction is taken
	assign out_adv   = !out_valid_q || rsp.ready;
	// stage 1 holds while the output is stalled; no new buffer read then, so the
	// read data stays put until stage 1 moves on
	assign req.ready = !s1_valid_s1 || out_adv;
	assign accept    = req.valid && req.ready;

	upsc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.func      (req.func),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.res       (res)
	);

	// blue in the low byte
	assign ram_wdata = {req.in_red, req.in_green, req.in_blue};

	// writes happen only while loading and reads only while emitting, so the two
	// never touch an entry in the same cycle
	upsc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				s1_valid_s1 <= res.valid;
			end
			if (out_adv) begin
				out_valid_q <= s1_valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.ready) begin
			s1_meta_s1 <= res.meta;
		end
		if (out_adv) begin
			out_meta_q <= s1_meta_s1;
			// a dropped push reports a black pixel
			out_pix_q  <= s1_meta_s1.dropped ? '0 : ram_rdata;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_blue  = out_pix_q[COLOR_W-1:0];
	assign rsp.out_green = out_pix_q[2*COLOR_W-1:COLOR_W];
	assign rsp.out_red   = out_pix_q[3*COLOR_W-1:2*COLOR_W];
	assign rsp.pad_bytes = out_meta_q.pad_bytes;
	assign rsp.row_end   = out_meta_q.row_end;
	assign rsp.group_end = out_meta_q.group_end;
	assign rsp.dropped   = out_meta_q.dropped;

endmodule

FILE: src/upsc_checker.sv
module upsc_checker import upsc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COLOR_W-1:0] out_blue,
	input logic [COLOR_W-1:0] out_green,
	input logic [COLOR_W-1:0] out_red,
	input logic [PAD_W-1:0]   pad_bytes,
	input logic               row_end,
	input logic               group_end,
	input logic               dropped
);

	// stalled result keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_blue) && $stable(out_green)
			&& $stable(out_red) && $stable(pad_bytes) && $stable(row_end)
			&& $stable(group_end) && $stable(dropped))
		else $error("result changed while stalled");

	// end of the last copy is also an end of row
	a_group_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && group_end |-> row_end)
		else $error("group_end without row_end");

	// padding only at row end
	a_pad_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pad_bytes != '0) |-> row_end)
		else $error("pad_bytes outside row end");

	// a discarded push carries nothing else
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> (out_blue == '0) && (out_green == '0) && (out_red == '0)
			&& (pad_bytes == '0) && !row_end && !group_end)
		else $error("dropped result with nonzero fields");

endmodule

bind pixel_replicate_upscaler_unit upsc_checker u_upsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_blue  (rsp.out_blue),
	.out_green (rsp.out_green),
	.out_red   (rsp.out_red),
	.pad_bytes (rsp.pad_bytes),
	.row_end   (rsp.row_end),
	.group_end (rsp.group_end),
	.dropped   (rsp.dropped)
);
